@@ hw/rtl/afc_pkg.sv @@
// Shared constants, types and reset values for the box culling pipeline.
package afc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int SHP_W     = PROD_W - FRAC_BITS;
  localparam int CLIP_W    = SHP_W + 2;
  localparam int QUO_W     = WORD_W - 1;
  localparam int INT_SHIFT = QUO_W - FRAC_BITS;
  localparam int NUM_REGS  = 8;
  localparam int IDX_W     = 8;
  localparam int CFG_W     = 2 * WORD_W;
  localparam int AXES      = 3;
  localparam int ROWS      = 4;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [CLIP_W-1:0] clip_t;

  // Control that travels with each corner through the pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tag_t;

  localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
  localparam logic [CFG_W-1:0] ONE_HI = ONE_LO << WORD_W;

  localparam logic [CFG_W-1:0] REG_RESET [NUM_REGS] = '{
    ONE_LO, '0, ONE_HI, '0, '0, ONE_LO, '0, ONE_HI
  };

  localparam word_t FIX_ONE  = word_t'(1) <<< FRAC_BITS;
  localparam word_t FIX_MONE = -FIX_ONE;
  localparam word_t FIX_ZERO = '0;
  localparam word_t SAT_POS  = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t SAT_NEG  = {1'b1, {(WORD_W-1){1'b0}}};

endpackage

@@ hw/rtl/afc_corner.sv @@
// Box capture and corner sequencer: one box in, eight corners out.
module afc_corner (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  afc_pkg::word_t       min_x_i,
  input  afc_pkg::word_t       min_y_i,
  input  afc_pkg::word_t       min_z_i,
  input  afc_pkg::word_t       max_x_i,
  input  afc_pkg::word_t       max_y_i,
  input  afc_pkg::word_t       max_z_i,
  output afc_pkg::word_t       corner_o [afc_pkg::AXES],
  output afc_pkg::tag_t        tag_o
);

  afc_pkg::word_t lo_q [afc_pkg::AXES];
  afc_pkg::word_t hi_q [afc_pkg::AXES];
  afc_pkg::word_t v_q  [afc_pkg::AXES];
  afc_pkg::tag_t  tag_q;
  logic [2:0]     cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           accept;

  assign in_stall_o = !adv_i || (busy_q && (cnt_q != 3'd7));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (adv_i) begin
      if (accept) begin
        busy_d = 1'b1;
        cnt_d  = '0;
      end else if (busy_q) begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      tag_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      if (adv_i) begin
        tag_q <= '{valid: busy_q, first: (cnt_q == 3'd0), last: (cnt_q == 3'd7)};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lo_q[0] <= min_x_i;
      lo_q[1] <= min_y_i;
      lo_q[2] <= min_z_i;
      hi_q[0] <= max_x_i;
      hi_q[1] <= max_y_i;
      hi_q[2] <= max_z_i;
    end
    if (adv_i) begin
      for (int j = 0; j < afc_pkg::AXES; j++) begin
        v_q[j] <= cnt_q[j] ? hi_q[j] : lo_q[j];
      end
    end
  end

  assign corner_o = v_q;
  assign tag_o    = tag_q;

  a_accept_blocks_next : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("box accepted while previous corners still pending");

  // A held stall keeps the sequencer at its first corner, so only a moving
  // pipeline ties that state to an accept in the previous cycle.
  a_first_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 3'd0 && $past(adv_i)) |-> $past(accept))
    else $error("corner sequence started without an accepted box");

endmodule

@@ hw/rtl/afc_xform.sv @@
// Matrix transform of one corner: registered products, then registered row sums.
module afc_xform (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic [afc_pkg::CFG_W-1:0] mat_i [afc_pkg::NUM_REGS],
  input  afc_pkg::word_t       v_i [afc_pkg::AXES],
  input  afc_pkg::tag_t        tag_i,
  output afc_pkg::clip_t       clip_o [afc_pkg::ROWS],
  output afc_pkg::tag_t        tag_o
);

  afc_pkg::word_t                     elem [afc_pkg::ROWS][afc_pkg::ROWS];
  logic signed [afc_pkg::PROD_W-1:0]  prod_q [afc_pkg::ROWS][afc_pkg::AXES];
  afc_pkg::word_t                     off_q  [afc_pkg::ROWS];
  afc_pkg::clip_t                     clip_q [afc_pkg::ROWS];
  afc_pkg::tag_t                      tag1_q, tag2_q;

  for (genvar r = 0; r < afc_pkg::ROWS; r++) begin : g_row
    for (genvar c = 0; c < afc_pkg::ROWS; c++) begin : g_col
      assign elem[r][c] = mat_i[2*r + c/2][(c%2)*afc_pkg::WORD_W +: afc_pkg::WORD_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else if (adv_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  // The floor of each scaled product is an arithmetic shift of the exact product.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int r = 0; r < afc_pkg::ROWS; r++) begin
        off_q[r] <= elem[r][3];
        for (int j = 0; j < afc_pkg::AXES; j++) begin
          prod_q[r][j] <= elem[r][j] * v_i[j];
        end
        clip_q[r] <= afc_pkg::clip_t'(off_q[r])
          + afc_pkg::clip_t'($signed(prod_q[r][0][afc_pkg::PROD_W-1:afc_pkg::FRAC_BITS]))
          + afc_pkg::clip_t'($signed(prod_q[r][1][afc_pkg::PROD_W-1:afc_pkg::FRAC_BITS]))
          + afc_pkg::clip_t'($signed(prod_q[r][2][afc_pkg::PROD_W-1:afc_pkg::FRAC_BITS]));
      end
    end
  end

  assign clip_o = clip_q;
  assign tag_o  = tag2_q;

endmodule

@@ hw/rtl/afc_div.sv @@
// Pipelined restoring divide of x, y and z by |w|, one quotient bit per stage.
module afc_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  afc_pkg::clip_t       clip_i [afc_pkg::ROWS],
  input  afc_pkg::tag_t        tag_i,
  output afc_pkg::word_t       res_o [afc_pkg::AXES],
  output afc_pkg::tag_t        tag_o
);

  localparam int NS = afc_pkg::QUO_W + 1;
  localparam int CW = afc_pkg::CLIP_W;

  // Front stage: magnitudes and signs.
  logic [CW-1:0]  nmag_q [afc_pkg::AXES];
  logic           negA_q [afc_pkg::AXES];
  logic           nzA_q  [afc_pkg::AXES];
  logic [CW-1:0]  dA_q;
  afc_pkg::tag_t  tagA_q;

  // Divide stages; index 0 holds the setup, index NS-1 the finished quotient.
  logic [CW-1:0]             r_q   [NS][afc_pkg::AXES];
  logic [afc_pkg::QUO_W-1:0] lw_q  [NS][afc_pkg::AXES];
  logic [afc_pkg::QUO_W-1:0] q_q   [NS][afc_pkg::AXES];
  logic                      neg_q [NS][afc_pkg::AXES];
  logic                      nz_q  [NS][afc_pkg::AXES];
  logic                      ovf_q [NS][afc_pkg::AXES];
  logic [CW-1:0]             d_q   [NS];
  afc_pkg::tag_t             tag_q [NS];

  afc_pkg::word_t res_q [afc_pkg::AXES];
  afc_pkg::tag_t  tagF_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tagA_q <= '0;
      tagF_q <= '0;
      for (int s = 0; s < NS; s++) begin
        tag_q[s] <= '0;
      end
    end else if (adv_i) begin
      tagA_q   <= tag_i;
      tag_q[0] <= tagA_q;
      for (int s = 1; s < NS; s++) begin
        tag_q[s] <= tag_q[s-1];
      end
      tagF_q <= tag_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dA_q <= clip_i[3][CW-1] ? CW'(-clip_i[3]) : CW'(clip_i[3]);
      for (int k = 0; k < afc_pkg::AXES; k++) begin
        nmag_q[k] <= clip_i[k][CW-1] ? CW'(-clip_i[k]) : CW'(clip_i[k]);
        negA_q[k] <= clip_i[k][CW-1];
        nzA_q[k]  <= (clip_i[k] == '0);
      end
      // Quotient is out of range exactly when the integer part reaches 2^INT_SHIFT.
      d_q[0] <= dA_q;
      for (int k = 0; k < afc_pkg::AXES; k++) begin
        r_q[0][k]   <= nmag_q[k] >> afc_pkg::INT_SHIFT;
        lw_q[0][k]  <= {nmag_q[k][afc_pkg::INT_SHIFT-1:0], {afc_pkg::FRAC_BITS{1'b0}}};
        q_q[0][k]   <= '0;
        neg_q[0][k] <= negA_q[k];
        nz_q[0][k]  <= nzA_q[k];
        ovf_q[0][k] <= ((nmag_q[k] >> afc_pkg::INT_SHIFT) >= dA_q);
      end
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_stage
    logic [CW:0] trial [afc_pkg::AXES];
    logic        take  [afc_pkg::AXES];

    always_comb begin
      for (int k = 0; k < afc_pkg::AXES; k++) begin
        trial[k] = {r_q[s-1][k], lw_q[s-1][k][afc_pkg::QUO_W-1]};
        take[k]  = (trial[k] >= {1'b0, d_q[s-1]});
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        d_q[s] <= d_q[s-1];
        for (int k = 0; k < afc_pkg::AXES; k++) begin
          r_q[s][k]   <= take[k] ? CW'(trial[k] - {1'b0, d_q[s-1]}) : CW'(trial[k]);
          lw_q[s][k]  <= lw_q[s-1][k] << 1;
          q_q[s][k]   <= {q_q[s-1][k][afc_pkg::QUO_W-2:0], take[k]};
          neg_q[s][k] <= neg_q[s-1][k];
          nz_q[s][k]  <= nz_q[s-1][k];
          ovf_q[s][k] <= ovf_q[s-1][k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < afc_pkg::AXES; k++) begin
        if (nz_q[NS-1][k]) begin
          res_q[k] <= afc_pkg::FIX_ZERO;
        end else if (ovf_q[NS-1][k]) begin
          res_q[k] <= neg_q[NS-1][k] ? afc_pkg::SAT_NEG : afc_pkg::SAT_POS;
        end else if (neg_q[NS-1][k]) begin
          res_q[k] <= -$signed({1'b0, q_q[NS-1][k]});
        end else begin
          res_q[k] <= $signed({1'b0, q_q[NS-1][k]});
        end
      end
    end
  end

  assign res_o = res_q;
  assign tag_o = tagF_q;

endmodule

@@ hw/rtl/afc_minmax.sv @@
// Projected box accumulation, overlap test and output register.
module afc_minmax (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  afc_pkg::word_t       n_i [afc_pkg::AXES],
  input  afc_pkg::tag_t        tag_i,
  output logic                 adv_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 visible_o
);

  afc_pkg::word_t lo_q [afc_pkg::AXES];
  afc_pkg::word_t hi_q [afc_pkg::AXES];
  logic           fin_q;
  logic           out_valid_q;
  logic           vis_q;
  logic           vis;

  assign adv_o = !out_valid_q || !out_stall_i;

  assign vis = (lo_q[0] <= afc_pkg::FIX_ONE) && (hi_q[0] >= afc_pkg::FIX_MONE)
            && (lo_q[1] <= afc_pkg::FIX_ONE) && (hi_q[1] >= afc_pkg::FIX_MONE)
            && (lo_q[2] <= afc_pkg::FIX_ONE) && (hi_q[2] >= afc_pkg::FIX_ZERO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      fin_q       <= tag_i.valid && tag_i.last;
      out_valid_q <= fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      if (tag_i.valid) begin
        for (int k = 0; k < afc_pkg::AXES; k++) begin
          if (tag_i.first || (n_i[k] < lo_q[k])) begin
            lo_q[k] <= n_i[k];
          end
          if (tag_i.first || (n_i[k] > hi_q[k])) begin
            hi_q[k] <= n_i[k];
          end
        end
      end
      if (fin_q) begin
        vis_q <= vis;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = vis_q;

  a_box_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> (lo_q[0] <= hi_q[0]) && (lo_q[1] <= hi_q[1]) && (lo_q[2] <= hi_q[2]))
    else $error("projected box has min above max");

endmodule

@@ hw/rtl/aabb_frustum_cull_top.sv @@
// Throughput: the sequencer feeds one corner per cycle, while the pipeline is not
// stalled, into the shared transform and divide pipeline; a new box is taken only
// when the sequencer is idle or issuing the last corner of the previous box.
// Reset: asynchronous, active low; clears all valid bits and loads the
// identity matrix. Configuration requests are always taken (ready stays high).
module aabb_frustum_cull_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [31:0]          min_x_i,
  input  logic signed [31:0]          min_y_i,
  input  logic signed [31:0]          min_z_i,
  input  logic signed [31:0]          max_x_i,
  input  logic signed [31:0]          max_y_i,
  input  logic signed [31:0]          max_z_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        visible_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [afc_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [afc_pkg::CFG_W-1:0]   cfg_data_i
);

  logic [afc_pkg::CFG_W-1:0] mat_q [afc_pkg::NUM_REGS];
  logic                      adv;
  afc_pkg::word_t            corner [afc_pkg::AXES];
  afc_pkg::tag_t             tag_c, tag_x, tag_d;
  afc_pkg::clip_t            clip [afc_pkg::ROWS];
  afc_pkg::word_t            ndc [afc_pkg::AXES];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= afc_pkg::REG_RESET;
    end else if (cfg_valid_i && cfg_ready_o
                 && (cfg_index_i < afc_pkg::IDX_W'(afc_pkg::NUM_REGS))) begin
      mat_q[cfg_index_i[$clog2(afc_pkg::NUM_REGS)-1:0]] <= cfg_data_i;
    end
  end

  afc_corner u_corner (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .min_x_i    (min_x_i),
    .min_y_i    (min_y_i),
    .min_z_i    (min_z_i),
    .max_x_i    (max_x_i),
    .max_y_i    (max_y_i),
    .max_z_i    (max_z_i),
    .corner_o   (corner),
    .tag_o      (tag_c)
  );

  afc_xform u_xform (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .mat_i  (mat_q),
    .v_i    (corner),
    .tag_i  (tag_c),
    .clip_o (clip),
    .tag_o  (tag_x)
  );

  afc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .clip_i (clip),
    .tag_i  (tag_x),
    .res_o  (ndc),
    .tag_o  (tag_d)
  );

  afc_minmax u_minmax (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (ndc),
    .tag_i       (tag_d),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .visible_o   (visible_o)
  );

endmodule

@@ tb/tb_aabb_frustum_cull_top.sv @@
// Testbench for the box culling block: projects random and directed boxes and checks visibility.
`timescale 1ns / 100ps

module tb_aabb_frustum_cull_top;

  typedef enum logic [afc_pkg::IDX_W-1:0] {
    R0C01 = 0, R0C23 = 1, R1C01 = 2, R1C23 = 3,
    R2C01 = 4, R2C23 = 5, R3C01 = 6, R3C23 = 7, RBAD = 8
  } reg_idx_e;

  typedef struct {
    afc_pkg::word_t lo [3];
    afc_pkg::word_t hi [3];
  } box_t;

  localparam int IDLE_LIMIT = 20000;
  localparam longint ONE_Q = 64'sd1 << afc_pkg::FRAC_BITS;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  afc_pkg::word_t min_x_i = '0, min_y_i = '0, min_z_i = '0;
  afc_pkg::word_t max_x_i = '0, max_y_i = '0, max_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic visible_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [afc_pkg::IDX_W-1:0] cfg_index_i = '0;
  logic [afc_pkg::CFG_W-1:0] cfg_data_i = '0;

  logic [afc_pkg::CFG_W-1:0] mat_shadow [afc_pkg::NUM_REGS];
  bit vis_expected [$];
  int err_count = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  aabb_frustum_cull_top u_dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic longint mat_coef(input int r, input int c);
    logic [afc_pkg::CFG_W-1:0] w;
    w = mat_shadow[r * 2 + c / 2];
    return longint'(afc_pkg::word_t'((c % 2) ? w[63:32] : w[31:0]));
  endfunction

  function automatic longint floor_q(input longint p);
    return p >>> afc_pkg::FRAC_BITS;
  endfunction

  // Fixed point n / |d|, magnitude truncated, saturated to the word range.
  function automatic longint ndc_div(input longint n, input longint d);
    longint unsigned nm, dm, ip, rem, q, mag;
    nm = n < 0 ? -n : n;
    dm = d < 0 ? -d : d;
    if (nm == 0) return 0;
    if (dm == 0) begin
      mag = 64'd1 << 31;
    end else begin
      ip = nm / dm;
      if (ip >= (64'd1 << (31 - afc_pkg::FRAC_BITS))) begin
        mag = 64'd1 << 31;
      end else begin
        rem = nm % dm;
        q = ip;
        for (int k = 0; k < afc_pkg::FRAC_BITS; k++) begin
          q = q << 1;
          rem = rem << 1;
          if (rem >= dm) begin
            q = q | 1;
            rem = rem - dm;
          end
        end
        mag = q;
      end
    end
    if (n > 0) return mag > 64'h7FFFFFFF ? 64'h7FFFFFFF : longint'(mag);
    return -longint'(mag);
  endfunction

  function automatic bit predict_visible(input box_t b);
    longint lo [3], hi [3], v [3], clip [4], acc, nv;
    for (int c = 0; c < 8; c++) begin
      for (int j = 0; j < 3; j++) v[j] = ((c >> j) & 1) ? b.hi[j] : b.lo[j];
      for (int i = 0; i < 4; i++) begin
        acc = mat_coef(i, 3);
        for (int j = 0; j < 3; j++) acc += floor_q(mat_coef(i, j) * v[j]);
        clip[i] = acc;
      end
      for (int i = 0; i < 3; i++) begin
        nv = ndc_div(clip[i], clip[3]);
        if (c == 0 || nv < lo[i]) lo[i] = nv;
        if (c == 0 || nv > hi[i]) hi[i] = nv;
      end
    end
    return lo[0] <= ONE_Q && hi[0] >= -ONE_Q && lo[1] <= ONE_Q && hi[1] >= -ONE_Q &&
           lo[2] <= ONE_Q && hi[2] >= 0;
  endfunction

  // Valid stays high after an accept; the block stalls for the next corners,
  // so the held request is not taken again before the next one replaces it.
  task automatic send_box(input box_t b);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    min_x_i <= b.lo[0]; min_y_i <= b.lo[1]; min_z_i <= b.lo[2];
    max_x_i <= b.hi[0]; max_y_i <= b.hi[1]; max_z_i <= b.hi[2];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    vis_expected.push_back(predict_visible(b));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (vis_expected.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [afc_pkg::CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx < afc_pkg::NUM_REGS) mat_shadow[idx] = val;
    @(posedge clk_i);
  endtask

  function automatic logic [afc_pkg::CFG_W-1:0] pack2(input longint a, input longint b);
    return {b[31:0], a[31:0]};
  endfunction

  function automatic afc_pkg::word_t rand_word();
    case ($urandom_range(0, 5))
      0: return afc_pkg::word_t'($urandom);
      1: return afc_pkg::word_t'($urandom_range(0, 4 * ONE_Q))
                - afc_pkg::word_t'(2 * ONE_Q);
      2: return $urandom_range(0, 1) ? afc_pkg::SAT_POS : afc_pkg::SAT_NEG;
      default: return afc_pkg::word_t'($urandom_range(0, 40 * ONE_Q))
                      - afc_pkg::word_t'(20 * ONE_Q);
    endcase
  endfunction

  function automatic box_t rand_box();
    box_t b;
    for (int j = 0; j < 3; j++) begin
      b.lo[j] = rand_word();
      b.hi[j] = $urandom_range(0, 3) == 0 ? rand_word()
              : b.lo[j] + afc_pkg::word_t'($urandom_range(0, 8 * ONE_Q));
    end
    return b;
  endfunction

  function automatic box_t mk_box(input afc_pkg::word_t a, input afc_pkg::word_t b);
    box_t r;
    for (int j = 0; j < 3; j++) begin
      r.lo[j] = a;
      r.hi[j] = b;
    end
    return r;
  endfunction

  // Random matrix: coefficients in [-2, 2], or arbitrary bit patterns when wild.
  task automatic load_random_matrix(input bit wild);
    for (int i = 0; i < afc_pkg::NUM_REGS; i++) begin
      if (wild) write_reg(reg_idx_e'(i), {$urandom, $urandom});
      else write_reg(reg_idx_e'(i),
             pack2($urandom_range(0, 4 * ONE_Q) - 2 * ONE_Q,
                   $urandom_range(0, 4 * ONE_Q) - 2 * ONE_Q));
    end
  endtask

  task automatic test_identity_directed();
    send_box(mk_box(afc_pkg::FIX_ZERO, afc_pkg::FIX_ZERO));
    send_box(mk_box(afc_pkg::FIX_ONE, afc_pkg::FIX_ONE));
    send_box(mk_box(afc_pkg::FIX_MONE, afc_pkg::FIX_MONE));
    send_box(mk_box(afc_pkg::FIX_ONE + 1, 2 * afc_pkg::FIX_ONE));
    send_box(mk_box(-2 * afc_pkg::FIX_ONE, afc_pkg::FIX_MONE - 1));
    send_box(mk_box(afc_pkg::SAT_NEG, afc_pkg::SAT_POS));
    send_box(mk_box(afc_pkg::SAT_POS, afc_pkg::SAT_NEG));
    send_box(mk_box(afc_pkg::SAT_POS, afc_pkg::SAT_POS));
    send_box(mk_box(afc_pkg::SAT_NEG, afc_pkg::SAT_NEG));
    send_box(mk_box(afc_pkg::word_t'(-1), afc_pkg::word_t'(-1)));
    drain();
  endtask

  task automatic test_zero_w();
    write_reg(R3C23, '0);
    send_box(mk_box(afc_pkg::FIX_ZERO, afc_pkg::FIX_ZERO));
    send_box(mk_box(afc_pkg::FIX_ONE, afc_pkg::FIX_ONE));
    send_box(mk_box(afc_pkg::FIX_MONE, afc_pkg::FIX_MONE));
    send_box(mk_box(afc_pkg::FIX_MONE, afc_pkg::FIX_ONE));
    drain();
    write_reg(R3C23, pack2(0, 1));
    send_box(mk_box(afc_pkg::SAT_POS, afc_pkg::SAT_POS));
    send_box(mk_box(afc_pkg::FIX_ONE, 3 * afc_pkg::FIX_ONE));
    drain();
    write_reg(RBAD, '1);
    write_reg(R3C23, pack2(0, ONE_Q));
  endtask

  task automatic test_extreme_matrix();
    for (int i = 0; i < afc_pkg::NUM_REGS; i++) write_reg(reg_idx_e'(i), '1);
    send_box(mk_box(afc_pkg::SAT_NEG, afc_pkg::SAT_POS));
    send_box(mk_box(afc_pkg::FIX_ONE, afc_pkg::FIX_ONE));
    drain();
    for (int i = 0; i < afc_pkg::NUM_REGS; i++) write_reg(reg_idx_e'(i), {2{afc_pkg::SAT_NEG}});
    send_box(mk_box(afc_pkg::SAT_NEG, afc_pkg::SAT_POS));
    send_box(mk_box(afc_pkg::FIX_MONE, afc_pkg::FIX_ONE));
    drain();
    for (int i = 0; i < afc_pkg::NUM_REGS; i++) write_reg(reg_idx_e'(i), {2{afc_pkg::SAT_POS}});
    send_box(mk_box(afc_pkg::SAT_POS, afc_pkg::SAT_NEG));
    send_box(mk_box(afc_pkg::FIX_ZERO, afc_pkg::FIX_ZERO));
    drain();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        for (int i = 0; i < afc_pkg::NUM_REGS; i++) begin
          write_reg(reg_idx_e'(i), afc_pkg::REG_RESET[i]);
        end
      end else begin
        load_random_matrix(ph == 7);
      end
      for (int n = 0; n < 210; n++) send_box(rand_box());
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < afc_pkg::NUM_REGS; i++) mat_shadow[i] = afc_pkg::REG_RESET[i];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_identity_directed();
    test_zero_w();
    test_extreme_matrix();
    test_random();
    stim_done = 1'b1;
  end

  // Sink side: random stalls, then compare each result against the oldest prediction.
  initial begin
    int hold;
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (vis_expected.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        bit want;
        want = vis_expected.pop_front();
        if (visible_o !== want)
          report_mismatch($sformatf("visible got %b want %b", visible_o, want));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_valid_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge clk_i);
    while (!stim_done && idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
    end else begin
      if (err_count == 0 && vis_expected.size() == 0) $display("Verification passed");
      else $display("Verification failed");
    end
    $finish;
  end

endmodule
